[rtl/pcpa_pkg.sv]
// ----------------------------------------------------------------------------
// Per-CPU page allocator package
// Shared types, codes and default sizes for the per-CPU page free-list
// allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

   localparam int NUM_CPUS_DEF   = 8;
   localparam int NUM_PAGES_DEF  = 32768;
   localparam int PAGE_SHIFT_DEF = 12;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_FIRST_FREE = 1'b0;
   localparam logic CSR_IDX_TOP        = 1'b1;

   localparam logic [CSR_DATA_W-1:0] FIRST_FREE_RESET = 32'h8000_0000;
   localparam logic [CSR_DATA_W-1:0] TOP_RESET        = 32'h8800_0000;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      RSP_ALLOC = 2'd0,
      RSP_FREED = 2'd1,
      RSP_EMPTY = 2'd2,
      RSP_BAD   = 2'd3
   } pcpa_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PUSH,
      ST_POP_HEAD,
      ST_POP_LINK
   } pcpa_state_type;

   typedef struct packed {
      logic         load;
      logic         latch_sel;
      logic         head_rd;
      logic         head_wr;
      logic         head_wr_page;
      logic         link_wr;
      logic         link_from_head;
      logic         link_rd;
      logic         rsp_valid;
      pcpa_rsp_type rsp_code;
   } pcpa_cmd_type;

   typedef struct packed {
      logic is_free;
      logic addr_bad;
      logic own_nonempty;
      logic any_nonempty;
   } pcpa_stat_type;

endpackage

[rtl/per_cpu_page_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// Per-CPU page free-list allocator
// One LIFO free list of pages per CPU in a shared link memory. An allocate
// takes from its own list, else from the lowest-numbered non-empty list.
//
//   Channel   Ports               Handshake
//   request   start, req_*        taken when start is high and busy is low
//   result    rsp_*               one cycle, marked by rsp_valid, no stall
//   config    psel .. pready      APB write in access cycle, pready tied high
//
// A bad free, an allocate with all lists empty, and a free to an empty list
// give their word straight after the decode state; a free to a non-empty list
// after the push state; a granted allocate after a head read, then a link
// read. The head and link memories are each accessed at most once per state.
// A new request is taken in the cycle the previous result is shown.
// Reset empties every list at once; the link memory needs no clearing.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator
   import pcpa_pkg::*;
#(
   parameter int NUM_CPUS   = NUM_CPUS_DEF,
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  logic [2:0]            req_cpu,
   input  logic [31:0]           req_page_address,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_granted_address,
   output logic [1:0]            rsp_status,
   output logic [2:0]            rsp_source_cpu,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CSR_DATA_W-1:0] first_free_ff;
   logic [CSR_DATA_W-1:0] top_ff;
   logic                  csr_wr;
   pcpa_cmd_type          cmd;
   pcpa_stat_type         stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_free_ff <= FIRST_FREE_RESET;
         top_ff        <= TOP_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == CSR_IDX_FIRST_FREE) begin
            first_free_ff <= pwdata;
         end else begin
            top_ff <= pwdata;
         end
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_TOP) ? top_ff : first_free_ff;

   pcpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   pcpa_dp #(
      .NUM_CPUS   (NUM_CPUS),
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_kind),
      .req_cpu             (req_cpu),
      .req_page_address    (req_page_address),
      .first_free_address  (first_free_ff),
      .top_address         (top_ff),
      .rsp_valid           (rsp_valid),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_source_cpu      (rsp_source_cpu)
   );

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_single_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_no_grant_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != RSP_ALLOC) |->
         (rsp_granted_address == 32'd0) && (rsp_source_cpu == 3'd0))
      else $error("non-allocate result carries an address or source");

   a_word_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a request in progress");

endmodule

[rtl/pcpa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module pcpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pcpa_ctrl.sv]
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences each request through address check, head access and link
// access, and issues the result strobe.
// ----------------------------------------------------------------------------
module pcpa_ctrl
   import pcpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  pcpa_stat_type stat,
   output pcpa_cmd_type  cmd,
   output logic          busy
);

   pcpa_state_type state_ff;
   pcpa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_free) begin
               if (!stat.addr_bad && stat.own_nonempty) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (stat.any_nonempty) begin
               state_in = ST_POP_HEAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PUSH:     state_in = ST_IDLE;
         ST_POP_HEAD: state_in = ST_POP_LINK;
         ST_POP_LINK: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_code = RSP_ALLOC;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_DECODE: begin
            cmd.latch_sel = 1'b1;
            if (stat.is_free) begin
               if (stat.addr_bad) begin
                  cmd.rsp_valid = 1'b1;
                  cmd.rsp_code  = RSP_BAD;
               end else if (stat.own_nonempty) begin
                  cmd.head_rd = 1'b1;
               end else begin
                  cmd.link_wr      = 1'b1;
                  cmd.head_wr      = 1'b1;
                  cmd.head_wr_page = 1'b1;
                  cmd.rsp_valid    = 1'b1;
                  cmd.rsp_code     = RSP_FREED;
               end
            end else if (stat.any_nonempty) begin
               cmd.head_rd = 1'b1;
            end else begin
               cmd.rsp_valid = 1'b1;
               cmd.rsp_code  = RSP_EMPTY;
            end
         end
         ST_PUSH: begin
            cmd.link_wr        = 1'b1;
            cmd.link_from_head = 1'b1;
            cmd.head_wr        = 1'b1;
            cmd.head_wr_page   = 1'b1;
            cmd.rsp_valid      = 1'b1;
            cmd.rsp_code       = RSP_FREED;
         end
         ST_POP_HEAD: begin
            cmd.link_rd = 1'b1;
         end
         ST_POP_LINK: begin
            cmd.head_wr   = 1'b1;
            cmd.rsp_valid = 1'b1;
            cmd.rsp_code  = RSP_ALLOC;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/pcpa_dp.sv]
// ----------------------------------------------------------------------------
// Allocator datapath
// Request registers, address check, list selection, head and link memories
// and the result registers.
// ----------------------------------------------------------------------------
module pcpa_dp
   import pcpa_pkg::*;
#(
   parameter int NUM_CPUS   = NUM_CPUS_DEF,
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  pcpa_cmd_type  cmd,
   output pcpa_stat_type stat,
   input  logic          req_kind,
   input  logic [2:0]    req_cpu,
   input  logic [31:0]   req_page_address,
   input  logic [31:0]   first_free_address,
   input  logic [31:0]   top_address,
   output logic          rsp_valid,
   output logic [31:0]   rsp_granted_address,
   output logic [1:0]    rsp_status,
   output logic [2:0]    rsp_source_cpu
);

   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int PG_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int HEAD_W = $clog2(NUM_PAGES + 1);
   localparam int SRC_W  = (CPU_W > 3) ? CPU_W : 3;
   localparam logic [32:0] OFS_MASK = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

   logic [CPU_W-1:0] cpu_map [8];

   logic              kind_ff;
   logic [CPU_W-1:0]  cpu_ff;
   logic [31:0]       pa_ff;
   logic [CPU_W-1:0]  sel_ff;
   logic [PG_W-1:0]   page_ff;
   logic [NUM_CPUS-1:0] nonempty_ff;
   logic [NUM_CPUS-1:0] nonempty_in;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_addr_ff;
   logic [1:0]        rsp_status_ff;
   logic [2:0]        rsp_src_ff;

   logic [32:0]       base;
   logic [32:0]       diff;
   logic [32:0]       page_full;
   logic [PG_W-1:0]   page_free;
   logic              addr_bad;
   logic [CPU_W-1:0]  first_idx;
   logic [CPU_W-1:0]  pick;
   logic [CPU_W-1:0]  list_idx;
   logic [CPU_W-1:0]  wr_idx;
   logic [HEAD_W-1:0] head_rd_data;
   logic [HEAD_W-1:0] head_wr_data;
   logic [HEAD_W-1:0] head_m1;
   logic [PG_W-1:0]   pop_page;
   logic [HEAD_W-1:0] link_rd_data;
   logic [HEAD_W-1:0] link_wr_data;
   logic [32:0]       grant_addr;
   logic [SRC_W-1:0]  src_wide;

   for (genvar v = 0; v < 8; v++) begin : g_cpu_map
      assign cpu_map[v] = CPU_W'(v % NUM_CPUS);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         cpu_ff  <= cpu_map[req_cpu];
         pa_ff   <= req_page_address;
      end
      if (cmd.latch_sel) begin
         sel_ff <= list_idx;
      end
      if (cmd.link_rd) begin
         page_ff <= pop_page;
      end
   end

   assign base      = ({1'b0, first_free_address} + OFS_MASK) & ~OFS_MASK;
   assign diff      = {1'b0, pa_ff} - base;
   assign page_full = diff >> PAGE_SHIFT;
   assign page_free = page_full[PG_W-1:0];

   always_comb begin
      addr_bad = ((pa_ff & OFS_MASK[31:0]) != 32'd0) ||
                 (pa_ff < first_free_address) ||
                 (pa_ff >= top_address) ||
                 ({1'b0, pa_ff} < base) ||
                 (page_full >= 33'(NUM_PAGES));
   end

   always_comb begin
      first_idx = '0;
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            first_idx = CPU_W'(i);
         end
      end
   end

   assign pick     = nonempty_ff[cpu_ff] ? cpu_ff : first_idx;
   assign list_idx = (kind_ff == KIND_FREE) ? cpu_ff : pick;
   assign wr_idx   = (kind_ff == KIND_FREE) ? cpu_ff : sel_ff;

   assign head_m1  = head_rd_data - HEAD_W'(1);
   assign pop_page = (head_m1 >= HEAD_W'(NUM_PAGES)) ? '0 : head_m1[PG_W-1:0];

   assign head_wr_data = cmd.head_wr_page ? (HEAD_W'(page_free) + HEAD_W'(1))
                                          : link_rd_data;
   assign link_wr_data = cmd.link_from_head ? head_rd_data : '0;

   always_comb begin
      nonempty_in = nonempty_ff;
      if (cmd.head_wr) begin
         nonempty_in[wr_idx] = cmd.head_wr_page || (link_rd_data != '0);
      end
   end

   pcpa_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (NUM_CPUS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (cmd.head_wr),
      .wr_addr (wr_idx),
      .wr_data (head_wr_data),
      .rd_en   (cmd.head_rd),
      .rd_addr (list_idx),
      .rd_data (head_rd_data)
   );

   pcpa_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (NUM_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.link_wr),
      .wr_addr (page_free),
      .wr_data (link_wr_data),
      .rd_en   (cmd.link_rd),
      .rd_addr (pop_page),
      .rd_data (link_rd_data)
   );

   assign grant_addr = base + (33'(page_ff) << PAGE_SHIFT);
   assign src_wide   = SRC_W'(sel_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= cmd.rsp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_valid) begin
         rsp_status_ff <= cmd.rsp_code;
         if (cmd.rsp_code == RSP_ALLOC) begin
            rsp_addr_ff <= grant_addr[31:0];
            rsp_src_ff  <= src_wide[2:0];
         end else begin
            rsp_addr_ff <= 32'd0;
            rsp_src_ff  <= 3'd0;
         end
      end
   end

   assign stat.is_free      = (kind_ff == KIND_FREE);
   assign stat.addr_bad     = addr_bad;
   assign stat.own_nonempty = nonempty_ff[cpu_ff];
   assign stat.any_nonempty = |nonempty_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_source_cpu      = rsp_src_ff;

endmodule
